>>> hdl/dq_pkg.sv
// Shared constants, types and word conversions for the double-ended queue.
package dq_pkg;

    localparam int DEPTH     = 1024;
    localparam int WORD_BITS = 32;
    localparam int REPLY_W   = 32;
    localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W     = $clog2(DEPTH + 1);

    typedef logic [WORD_BITS-1:0] t_word;
    typedef logic [REPLY_W-1:0]   t_reply;
    typedef logic [IDX_W-1:0]     t_index;
    typedef logic [CNT_W-1:0]     t_count;

    typedef enum logic [2:0] {
        FN_PUSH_FRONT = 3'd0,
        FN_PUSH_BACK  = 3'd1,
        FN_POP_FRONT  = 3'd2,
        FN_POP_BACK   = 3'd3,
        FN_SIZE       = 3'd4,
        FN_EMPTY      = 3'd5,
        FN_FRONT      = 3'd6,
        FN_BACK       = 3'd7
    } t_func;

    // Per-chain control: shift toward the tail, shift toward cell 0,
    // or write the cell whose index equals the fill count.
    typedef struct packed {
        logic shr;
        logic shl;
        logic wr;
    } t_chain_ctl;

    function automatic t_word value_to_word(input logic signed [REPLY_W-1:0] v);
        return t_word'(WORD_BITS'(v));
    endfunction

    function automatic t_reply word_to_reply(input t_word w);
        logic signed [WORD_BITS-1:0] s;
        s = $signed(w);
        return t_reply'(REPLY_W'(s));
    endfunction

endpackage

>>> hdl/dq_cell.sv
// One storage cell of a shift chain: holds a word, takes a neighbor's or a new one.
module dq_cell (
    input  logic                 i_clk,
    input  dq_pkg::t_chain_ctl   i_ctl,
    input  dq_pkg::t_index       i_index,
    input  dq_pkg::t_count       i_count,
    input  dq_pkg::t_word        i_value,
    input  dq_pkg::t_word        i_left,
    input  dq_pkg::t_word        i_right,
    output dq_pkg::t_word        o_data
);

    dq_pkg::t_word r_data;
    dq_pkg::t_word n_data;

    always_comb begin
        n_data = r_data;
        priority if (i_ctl.shr) begin
            n_data = i_left;
        end else if (i_ctl.shl) begin
            n_data = i_right;
        end else if (i_ctl.wr && (dq_pkg::CNT_W'(i_index) == i_count)) begin
            n_data = i_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

>>> hdl/dq_chain.sv
// Row of cells ordered from one end of the queue; cell 0 holds that end's word.
module dq_chain (
    input  logic                 i_clk,
    input  dq_pkg::t_chain_ctl   i_ctl,
    input  dq_pkg::t_count       i_count,
    input  dq_pkg::t_word        i_value,
    output dq_pkg::t_word        o_head
);

    dq_pkg::t_word w_data [dq_pkg::DEPTH];

    for (genvar g = 0; g < dq_pkg::DEPTH; g++) begin : g_cell
        dq_pkg::t_word w_left;
        dq_pkg::t_word w_right;

        if (g == 0) begin : g_first
            assign w_left = i_value;
        end else begin : g_mid_l
            assign w_left = w_data[g-1];
        end

        if (g == dq_pkg::DEPTH - 1) begin : g_last
            assign w_right = w_data[g];
        end else begin : g_mid_r
            assign w_right = w_data[g+1];
        end

        dq_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (i_ctl),
            .i_index (dq_pkg::IDX_W'(g)),
            .i_count (i_count),
            .i_value (i_value),
            .i_left  (w_left),
            .i_right (w_right),
            .o_data  (w_data[g])
        );
    end

    assign o_head = w_data[0];

endmodule

>>> hdl/double_ended_queue.sv
// Top level of the double-ended queue of signed words.
//
// Usage: a request is taken at a rising edge with start high and busy low.
// busy is always low, so one request can be issued every cycle.
// i_func picks the command (push front/back, pop front/back, size, empty,
// peek front/back); i_value is the word for a push.
// Pushes give no result. Every other request gives one result on o_reply,
// o_was_empty and o_is_full, marked by o_strobe for one cycle, in the cycle
// right after the request (throughput 1 request per cycle).
// The queue is two rows of DEPTH cells, one ordered from the front and one
// from the back; a push or pop shifts one row a cell, a push also writes one
// cell of the other, so each command finishes in its own cycle.
// o_is_full shows the full state before the request took effect. A pop or
// peek on an empty queue replies all ones with o_was_empty set. A push on a
// full queue is dropped.
// Reset empties the queue and clears the strobe; nothing needs sweeping.
// The receiver cannot stall; results must be taken when strobed.
module double_ended_queue (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_func,
    input  logic signed [31:0] i_value,
    output logic        o_strobe,
    output logic signed [31:0] o_reply,
    output logic        o_was_empty,
    output logic        o_is_full
);

    dq_pkg::t_count     r_count;
    dq_pkg::t_count     n_count;
    logic               r_strobe;
    logic               n_strobe;
    dq_pkg::t_reply     r_reply;
    dq_pkg::t_reply     n_reply;
    logic               r_was_empty;
    logic               n_was_empty;
    logic               r_is_full;
    logic               n_is_full;

    dq_pkg::t_chain_ctl w_front_ctl;
    dq_pkg::t_chain_ctl w_back_ctl;
    dq_pkg::t_word      w_front_head;
    dq_pkg::t_word      w_back_head;
    dq_pkg::t_word      w_word;
    dq_pkg::t_func      w_func;
    logic               w_full;
    logic               w_empty;

    assign busy    = 1'b0;
    assign w_func  = dq_pkg::t_func'(i_func);
    assign w_word  = dq_pkg::value_to_word(i_value);
    assign w_full  = (r_count == dq_pkg::CNT_W'(dq_pkg::DEPTH));
    assign w_empty = (r_count == '0);

    always_comb begin
        n_count     = r_count;
        n_strobe    = 1'b0;
        n_reply     = r_reply;
        n_was_empty = 1'b0;
        n_is_full   = w_full;
        w_front_ctl = '0;
        w_back_ctl  = '0;
        if (start && !busy) begin
            unique case (w_func)
                dq_pkg::FN_PUSH_FRONT: begin
                    if (!w_full) begin
                        w_front_ctl.shr = 1'b1;
                        w_back_ctl.wr   = 1'b1;
                        n_count         = r_count + 1'b1;
                    end
                end
                dq_pkg::FN_PUSH_BACK: begin
                    if (!w_full) begin
                        w_back_ctl.shr  = 1'b1;
                        w_front_ctl.wr  = 1'b1;
                        n_count         = r_count + 1'b1;
                    end
                end
                dq_pkg::FN_POP_FRONT, dq_pkg::FN_FRONT: begin
                    n_strobe = 1'b1;
                    if (w_empty) begin
                        n_reply     = '1;
                        n_was_empty = 1'b1;
                    end else begin
                        n_reply = dq_pkg::word_to_reply(w_front_head);
                        if (w_func == dq_pkg::FN_POP_FRONT) begin
                            w_front_ctl.shl = 1'b1;
                            n_count         = r_count - 1'b1;
                        end
                    end
                end
                dq_pkg::FN_POP_BACK, dq_pkg::FN_BACK: begin
                    n_strobe = 1'b1;
                    if (w_empty) begin
                        n_reply     = '1;
                        n_was_empty = 1'b1;
                    end else begin
                        n_reply = dq_pkg::word_to_reply(w_back_head);
                        if (w_func == dq_pkg::FN_POP_BACK) begin
                            w_back_ctl.shl = 1'b1;
                            n_count        = r_count - 1'b1;
                        end
                    end
                end
                dq_pkg::FN_SIZE: begin
                    n_strobe = 1'b1;
                    n_reply  = dq_pkg::t_reply'(dq_pkg::REPLY_W'(r_count));
                end
                dq_pkg::FN_EMPTY: begin
                    n_strobe = 1'b1;
                    n_reply  = dq_pkg::t_reply'({{(dq_pkg::REPLY_W-1){1'b0}}, w_empty});
                end
                default: begin
                    n_strobe = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_count  <= n_count;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_reply     <= n_reply;
        r_was_empty <= n_was_empty;
        r_is_full   <= n_is_full;
    end

    dq_chain u_front (
        .i_clk   (i_clk),
        .i_ctl   (w_front_ctl),
        .i_count (r_count),
        .i_value (w_word),
        .o_head  (w_front_head)
    );

    dq_chain u_back (
        .i_clk   (i_clk),
        .i_ctl   (w_back_ctl),
        .i_count (r_count),
        .i_value (w_word),
        .o_head  (w_back_head)
    );

    assign o_strobe    = r_strobe;
    assign o_reply     = $signed(r_reply);
    assign o_was_empty = r_was_empty;
    assign o_is_full   = r_is_full;

endmodule

>>> hdl/dq_checker.sv
// Port-level checks for the double-ended queue, bound to the top level.
module dq_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic [2:0]  i_func,
    input logic        o_strobe,
    input logic [31:0] o_reply,
    input logic        o_was_empty,
    input logic        o_is_full
);

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_func[2] || i_func[1])) |=> o_strobe)
        else $error("result request gave no strobe");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(start && !busy && (i_func[2] || i_func[1])) |=> !o_strobe)
        else $error("strobe without a result request");

    a_empty_reply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_was_empty) |-> (o_reply == 32'hFFFF_FFFF))
        else $error("empty pop or peek did not reply all ones");

    a_full_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_is_full) |-> !o_was_empty)
        else $error("queue flagged both full and empty");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_strobe)
        else $error("strobe right after reset");

endmodule

bind double_ended_queue dq_checker u_dq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .i_func      (i_func),
    .o_strobe    (o_strobe),
    .o_reply     (o_reply),
    .o_was_empty (o_was_empty),
    .o_is_full   (o_is_full)
);

>>> sim/testbench.sv
// Self-checking testbench for the double-ended queue: directed table, then random walks.
`timescale 1ns / 100ps

module testbench;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int N_DIRECTED   = 24;
    localparam int RANDOM_ITEMS = 212;
    localparam int DRAIN_CYCLES = 4;

    typedef struct {
        dq_pkg::t_reply reply;
        logic           was_empty;
        logic           is_full;
    } t_reply_rec;

    typedef struct {
        dq_pkg::t_func fn;
        logic [31:0]   val;
        bit            typed;
        t_reply_rec    want;
    } t_dir_row;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic start;
    logic busy;
    logic [2:0] i_func;
    logic signed [31:0] i_value;
    logic o_strobe;
    logic signed [31:0] o_reply;
    logic o_was_empty;
    logic o_is_full;

    double_ended_queue uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_func      (i_func),
        .i_value     (i_value),
        .o_strobe    (o_strobe),
        .o_reply     (o_reply),
        .o_was_empty (o_was_empty),
        .o_is_full   (o_is_full)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Predictor state
    dq_pkg::t_word  q_cells [dq_pkg::DEPTH];
    dq_pkg::t_index q_head;
    dq_pkg::t_index q_tail;
    dq_pkg::t_count q_fill;

    t_reply_rec expected_replies [$];
    t_reply_rec blank_rec = '{32'd0, 1'b0, 1'b0};
    t_reply_rec row_want;
    bit         row_typed;
    t_reply_rec pred_rec;
    t_reply_rec oldest;
    bit         pred_has;

    int cycle_count = 0;
    int error_count = 0;
    int sender_idle_pct = 0;
    int drv_fill = 0;

    t_dir_row directed_rows [N_DIRECTED];

    function automatic dq_pkg::t_index wrap_inc(input dq_pkg::t_index p);
        return (int'(p) + 1 >= dq_pkg::DEPTH) ? dq_pkg::t_index'(0)
                                              : dq_pkg::t_index'(int'(p) + 1);
    endfunction

    function automatic dq_pkg::t_index wrap_dec(input dq_pkg::t_index p);
        return (p == dq_pkg::t_index'(0)) ? dq_pkg::t_index'(dq_pkg::DEPTH - 1)
                                          : dq_pkg::t_index'(int'(p) - 1);
    endfunction

    function automatic void predict_deque(input dq_pkg::t_func fn, input logic [31:0] val,
                                          output bit has_reply, output t_reply_rec rec);
        logic full;
        logic empty;
        logic signed [63:0] v64;
        dq_pkg::t_word w;
        logic signed [dq_pkg::WORD_BITS-1:0] sw;
        dq_pkg::t_index last;
        full  = (q_fill >= dq_pkg::DEPTH);
        empty = (q_fill == 0);
        v64   = $signed(val);
        w     = v64[dq_pkg::WORD_BITS-1:0];
        has_reply     = 1'b1;
        rec.reply     = '0;
        rec.was_empty = 1'b0;
        rec.is_full   = full;
        case (fn)
            dq_pkg::FN_PUSH_FRONT, dq_pkg::FN_PUSH_BACK: begin
                has_reply = 1'b0;
                if (!full) begin
                    if (fn == dq_pkg::FN_PUSH_FRONT) begin
                        q_head = wrap_dec(q_head);
                        q_cells[q_head] = w;
                    end else begin
                        q_cells[q_tail] = w;
                        q_tail = wrap_inc(q_tail);
                    end
                    q_fill = q_fill + 1'b1;
                end
            end
            dq_pkg::FN_POP_FRONT, dq_pkg::FN_FRONT: begin
                if (empty) begin
                    rec.reply     = '1;
                    rec.was_empty = 1'b1;
                end else begin
                    sw = q_cells[q_head];
                    rec.reply = sw;
                    if (fn == dq_pkg::FN_POP_FRONT) begin
                        q_head = wrap_inc(q_head);
                        q_fill = q_fill - 1'b1;
                    end
                end
            end
            dq_pkg::FN_POP_BACK, dq_pkg::FN_BACK: begin
                if (empty) begin
                    rec.reply     = '1;
                    rec.was_empty = 1'b1;
                end else begin
                    last = wrap_dec(q_tail);
                    sw = q_cells[last];
                    rec.reply = sw;
                    if (fn == dq_pkg::FN_POP_BACK) begin
                        q_tail = last;
                        q_fill = q_fill - 1'b1;
                    end
                end
            end
            dq_pkg::FN_SIZE: rec.reply = dq_pkg::t_reply'(q_fill);
            default:         rec.reply = empty ? dq_pkg::t_reply'(1) : dq_pkg::t_reply'(0);
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("ERROR cycle %0d: %s got %h expected %h", cycle_count, what, got, want);
        error_count++;
    endtask

    // Checker and predictor, sampled at the rising edge
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout with %0d results outstanding", expected_replies.size());
            $display("*** FAILED ***");
            $finish;
        end else if (i_rst_n) begin
            if (o_strobe) begin
                if (expected_replies.size() == 0) begin
                    report_mismatch("result with nothing expected", o_reply, '0);
                end else begin
                    oldest = expected_replies[0];
                    expected_replies.delete(0);
                    if (o_reply !== oldest.reply)
                        report_mismatch("o_reply", o_reply, oldest.reply);
                    if (o_was_empty !== oldest.was_empty)
                        report_mismatch("o_was_empty", 32'(o_was_empty),
                                        32'(oldest.was_empty));
                    if (o_is_full !== oldest.is_full)
                        report_mismatch("o_is_full", 32'(o_is_full), 32'(oldest.is_full));
                end
            end
            if (start && !busy) begin
                predict_deque(dq_pkg::t_func'(i_func), i_value, pred_has, pred_rec);
                if (pred_has) begin
                    if (row_typed)
                        pred_rec = row_want;
                    expected_replies.insert(expected_replies.size(), pred_rec);
                end
            end
        end
    end

    task automatic issue(input dq_pkg::t_func fn, input logic [31:0] val, input bit typed,
                         input t_reply_rec want);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
        @(negedge i_clk);
        start     <= 1'b1;
        i_func    <= fn;
        i_value   <= val;
        row_typed <= typed;
        row_want  <= want;
        do @(posedge i_clk); while (busy);
        case (fn)
            dq_pkg::FN_PUSH_FRONT, dq_pkg::FN_PUSH_BACK:
                if (drv_fill < dq_pkg::DEPTH) drv_fill++;
            dq_pkg::FN_POP_FRONT, dq_pkg::FN_POP_BACK:
                if (drv_fill > 0) drv_fill--;
            default: ;
        endcase
    endtask

    function automatic logic [31:0] rand_word();
        if ($urandom_range(0, 9) == 0) begin
            case ($urandom_range(0, 3))
                0:       return 32'h0000_0000;
                1:       return 32'hFFFF_FFFF;
                2:       return 32'h8000_0000;
                default: return 32'h7FFF_FFFF;
            endcase
        end
        return $urandom;
    endfunction

    function automatic dq_pkg::t_func rand_query();
        return dq_pkg::t_func'($urandom_range(dq_pkg::FN_POP_FRONT, dq_pkg::FN_BACK));
    endfunction

    // Random walk: grow toward a random target depth, then shrink, with noise
    task automatic random_walk(input int count);
        bit grow;
        int target;
        int r;
        dq_pkg::t_func fn;
        grow = 1'b1;
        target = $urandom_range(4, 60);
        for (int k = 0; k < count; k++) begin
            if (grow && drv_fill >= target) grow = 1'b0;
            if (!grow && drv_fill == 0) begin
                grow = 1'b1;
                target = $urandom_range(4, 60);
            end
            if ($urandom_range(0, 99) < 3) grow = !grow;
            r = $urandom_range(0, 99);
            if (grow)
                fn = (r < 35) ? dq_pkg::FN_PUSH_FRONT :
                     (r < 70) ? dq_pkg::FN_PUSH_BACK : rand_query();
            else if (r < 15)
                fn = dq_pkg::t_func'($urandom_range(dq_pkg::FN_PUSH_FRONT,
                                                    dq_pkg::FN_PUSH_BACK));
            else if (r < 65)
                fn = dq_pkg::t_func'($urandom_range(dq_pkg::FN_POP_FRONT,
                                                    dq_pkg::FN_POP_BACK));
            else
                fn = rand_query();
            issue(fn, rand_word(), 1'b0, blank_rec);
        end
    endtask

    initial begin
        int idle_table [4];
        i_rst_n   = 1'b0;
        start     = 1'b0;
        i_func    = dq_pkg::FN_SIZE;
        i_value   = '0;
        row_typed = 1'b0;
        row_want  = blank_rec;
        q_head    = '0;
        q_tail    = '0;
        q_fill    = '0;
        idle_table = '{0, 50, 0, 37};

        directed_rows = '{
            '{dq_pkg::FN_SIZE,       32'h1234_5678, 1'b1, '{32'h0000_0000, 1'b0, 1'b0}},
            '{dq_pkg::FN_EMPTY,      32'h1234_5678, 1'b1, '{32'h0000_0001, 1'b0, 1'b0}},
            '{dq_pkg::FN_POP_FRONT,  32'h1234_5678, 1'b1, '{32'hFFFF_FFFF, 1'b1, 1'b0}},
            '{dq_pkg::FN_POP_BACK,   32'h1234_5678, 1'b1, '{32'hFFFF_FFFF, 1'b1, 1'b0}},
            '{dq_pkg::FN_FRONT,      32'h1234_5678, 1'b1, '{32'hFFFF_FFFF, 1'b1, 1'b0}},
            '{dq_pkg::FN_BACK,       32'h1234_5678, 1'b1, '{32'hFFFF_FFFF, 1'b1, 1'b0}},
            '{dq_pkg::FN_PUSH_BACK,  32'h7FFF_FFFF, 1'b0, '{32'h0000_0000, 1'b0, 1'b0}},
            '{dq_pkg::FN_PUSH_FRONT, 32'h8000_0000, 1'b0, '{32'h0000_0000, 1'b0, 1'b0}},
            '{dq_pkg::FN_FRONT,      32'h0000_0000, 1'b1, '{32'h8000_0000, 1'b0, 1'b0}},
            '{dq_pkg::FN_BACK,       32'h0000_0000, 1'b1, '{32'h7FFF_FFFF, 1'b0, 1'b0}},
            '{dq_pkg::FN_SIZE,       32'hFFFF_FFFF, 1'b1, '{32'h0000_0002, 1'b0, 1'b0}},
            '{dq_pkg::FN_EMPTY,      32'hFFFF_FFFF, 1'b1, '{32'h0000_0000, 1'b0, 1'b0}},
            '{dq_pkg::FN_PUSH_FRONT, 32'hFFFF_FFFF, 1'b0, '{32'h0000_0000, 1'b0, 1'b0}},
            '{dq_pkg::FN_PUSH_BACK,  32'h0000_0000, 1'b0, '{32'h0000_0000, 1'b0, 1'b0}},
            '{dq_pkg::FN_POP_BACK,   32'h5555_5555, 1'b1, '{32'h0000_0000, 1'b0, 1'b0}},
            '{dq_pkg::FN_POP_FRONT,  32'hAAAA_AAAA, 1'b1, '{32'hFFFF_FFFF, 1'b0, 1'b0}},
            '{dq_pkg::FN_POP_FRONT,  32'h0000_0000, 1'b1, '{32'h8000_0000, 1'b0, 1'b0}},
            '{dq_pkg::FN_POP_FRONT,  32'h0000_0000, 1'b1, '{32'h7FFF_FFFF, 1'b0, 1'b0}},
            '{dq_pkg::FN_POP_BACK,   32'h0000_0000, 1'b1, '{32'hFFFF_FFFF, 1'b1, 1'b0}},
            '{dq_pkg::FN_PUSH_BACK,  32'hA5A5_A5A5, 1'b0, '{32'h0000_0000, 1'b0, 1'b0}},
            '{dq_pkg::FN_PUSH_FRONT, 32'h5A5A_5A5A, 1'b0, '{32'h0000_0000, 1'b0, 1'b0}},
            '{dq_pkg::FN_POP_BACK,   32'h0000_0000, 1'b0, '{32'h0000_0000, 1'b0, 1'b0}},
            '{dq_pkg::FN_POP_FRONT,  32'h0000_0000, 1'b0, '{32'h0000_0000, 1'b0, 1'b0}},
            '{dq_pkg::FN_EMPTY,      32'h0000_0000, 1'b1, '{32'h0000_0001, 1'b0, 1'b0}}
        };

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        sender_idle_pct = 0;
        foreach (directed_rows[k])
            issue(directed_rows[k].fn, directed_rows[k].val, directed_rows[k].typed,
                  directed_rows[k].want);

        for (int p = 0; p < 4; p++) begin
            sender_idle_pct = idle_table[p];
            random_walk(RANDOM_ITEMS);
        end

        @(negedge i_clk);
        start <= 1'b0;
        while (expected_replies.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
